FILE: design/hierarchical_dirty_page_tracker_assert.svh
// assertion macros for the dirty page tracker
// no dependencies; taken in by the modules that check their own logic
`ifndef HIERARCHICAL_DIRTY_PAGE_TRACKER_ASSERT_SVH
`define HIERARCHICAL_DIRTY_PAGE_TRACKER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define HDPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define HDPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/hdpt_pkg.sv
// shared types and constants of the dirty page tracker
// no dependencies; used by hdpt_div and hierarchical_dirty_page_tracker
package hdpt_pkg;

  localparam int unsigned PAGES    = 256;
  localparam int unsigned NODES    = 2 * PAGES;
  localparam int unsigned PAGE_W   = $clog2(PAGES);
  localparam int unsigned NODE_W   = $clog2(NODES);
  localparam int unsigned LVL_W    = $clog2(PAGE_W + 1);
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [15:0] EPOCH_WRAP   = 16'd65000;
  localparam logic [6:0]  ROUND_LAST   = 7'd99;
  localparam logic [1:0]  WARM_STAGES  = 2'd2;
  localparam logic [1:0]  WARM_DONE    = 2'd3;
  localparam logic [15:0] PROTECT_RST  = 16'd30;
  localparam logic [15:0] LOG_COST_RST = 16'd100;

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_END   = 2'd1,
    OP_ROUND = 2'd2
  } op_e;

  typedef enum logic [7:0] {
    REG_PROTECT  = 8'd0,
    REG_LOG_COST = 8'd1
  } reg_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] page;
  } in_t;

  typedef struct packed {
    logic [7:0]  part_start;
    logic [8:0]  part_pages;
    logic [15:0] log_total;
    logic        model_built;
  } out_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] cost;
  } node_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

FILE: design/hierarchical_dirty_page_tracker.sv
// dirty page tracker over a binary tree of page partitions
// depends on hdpt_pkg, hdpt_div and hierarchical_dirty_page_tracker_assert.svh
//
// usage: one input beat per operation (touch, end interval, model round)
// on in_valid_i/in_ready_o; one result beat per operation on
// out_valid_o/out_ready_i; register writes on cfg_valid_i/cfg_ready_o,
// always ready. one operation is in work at a time; in_ready_o is high
// when the sequencer is idle, even while a result waits in the output
// register. a touch reads each ancestor from the node memory, and an
// ancestor not yet marked this epoch adds a multiply and a 32-step
// serial divide. an end interval at the epoch wrap sweeps the epoch
// memory; the model round that rebuilds the partitions passes each inner
// node through the states S_RA, S_RB, S_RC and S_RE. after reset a
// clearing pass over both node memories runs before the first input beat.
// a stalled receiver holds the result; the next result waits in the
// sequencer until the output register frees.
module hierarchical_dirty_page_tracker import hdpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "hierarchical_dirty_page_tracker_assert.svh"

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CLR  = 13'b0000000000010,
    S_RD   = 13'b0000000000100,
    S_CHK  = 13'b0000000001000,
    S_MUL  = 13'b0000000010000,
    S_DIVS = 13'b0000000100000,
    S_DIVW = 13'b0000001000000,
    S_WB   = 13'b0000010000000,
    S_RA   = 13'b0000100000000,
    S_RB   = 13'b0001000000000,
    S_RC   = 13'b0010000000000,
    S_RE   = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } st_e;

  st_e state_q, state_d;

  logic [15:0] protect_q, log_cost_q;
  logic [15:0] epoch_q, epoch_d;
  logic [15:0] log_q, log_d;
  logic [31:0] round_q, round_d;
  logic [6:0]  rmod_q, rmod_d;
  logic [1:0]  warm_q, warm_d;
  logic [PAGES-1:0] ivld_q, ivld_d;
  logic        clr_all_q, clr_all_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [1:0]  op_q, op_d;
  logic        built_q, built_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [NODE_W-1:0] pick_q, pick_d;
  logic [LVL_W-1:0]  plvl_q, plvl_d;
  logic [PAGE_W-1:0] par_q, par_d;
  logic [31:0] cnt_q, cnt_d;
  logic [47:0] prod_q;
  logic [31:0] c0_q, c1_q;

  logic [15:0] ep_mem [NODES];
  node_t       dm_mem [NODES];
  logic [15:0] ep_rd_q;
  node_t       dm_rd_q;
  logic [NODE_W-1:0] rd_addr, ep_waddr, dm_waddr;
  logic        ep_we, dm_we;
  logic [15:0] ep_wdata;
  node_t       dm_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [32:0] cost_sum, kid_sum;
  logic [31:0] cost_new, kid_cost;
  logic [16:0] pstart_sh;
  logic [16:0] log_sum;
  logic [8:0]  tsize;

  hdpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    div_req.start    = (state_q == S_DIVS);
    div_req.dividend = {8'd0, prod_q, 8'd0} << lvl_q;
    div_req.divisor  = {1'b0, round_q} + 33'd1;
    cost_sum = {1'b0, div_rsp.quot} + {9'd0, protect_q, 8'd0};
    cost_new = (div_rsp.sat || cost_sum[32]) ? '1 : cost_sum[31:0];
    kid_sum  = {1'b0, c0_q} + {1'b0, c1_q};
    kid_cost = kid_sum[32] ? '1 : kid_sum[31:0];
    pstart_sh = {8'd0, pick_q} << plvl_q;
    tsize     = 9'd1 << plvl_q;
    log_sum   = {1'b0, log_q} + {8'd0, tsize};
  end

  always_comb begin
    rd_addr = node_q;
    case (state_q)
      S_RA:    rd_addr = {par_q, 1'b0};
      S_RB:    rd_addr = {par_q, 1'b1};
      S_RC:    rd_addr = {1'b0, par_q};
      default: rd_addr = node_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    epoch_d = epoch_q;
    log_d = log_q;
    round_d = round_q;
    rmod_d = rmod_q;
    warm_d = warm_q;
    ivld_d = ivld_q;
    clr_all_d = clr_all_q;
    clr_d = clr_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    op_d = op_q;
    built_d = built_q;
    node_d = node_q;
    lvl_d = lvl_q;
    pick_d = pick_q;
    plvl_d = plvl_q;
    par_d = par_q;
    cnt_d = cnt_q;
    ep_we = 1'b0;
    ep_waddr = node_q;
    ep_wdata = epoch_q;
    dm_we = 1'b0;
    dm_waddr = node_q;
    dm_wdata = '{count: cnt_q, cost: cost_new};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.operation;
          built_d = 1'b0;
          state_d = S_DONE;
          case (in_data_i.operation)
            OP_TOUCH: begin
              node_d = {1'b1, in_data_i.page[PAGE_W-1:0]};
              lvl_d = '0;
              state_d = S_RD;
            end
            OP_END: begin
              log_d = '0;
              if (epoch_q == EPOCH_WRAP) begin
                epoch_d = 16'd1;
                clr_all_d = 1'b0;
                clr_d = '0;
                state_d = S_CLR;
              end else begin
                epoch_d = epoch_q + 16'd1;
              end
            end
            OP_ROUND: begin
              round_d = round_q + 32'd1;
              rmod_d = (rmod_q == ROUND_LAST) ? 7'd0 : rmod_q + 7'd1;
              if (rmod_q == ROUND_LAST && warm_q < WARM_STAGES) begin
                ivld_d = '0;
                if (warm_q + 2'd1 == WARM_STAGES) begin
                  warm_d = WARM_DONE;
                  built_d = 1'b1;
                  par_d = '1;
                  state_d = S_RA;
                end else begin
                  warm_d = warm_q + 2'd1;
                end
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        ep_we = 1'b1;
        ep_waddr = clr_q;
        ep_wdata = '0;
        dm_we = clr_all_q;
        dm_waddr = clr_q;
        dm_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = clr_all_q ? S_IDLE : S_DONE;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (lvl_q == '0 || ivld_q[node_q[PAGE_W-1:0]]) begin
          pick_d = node_q;
          plvl_d = lvl_q;
        end
        if (ep_rd_q != epoch_q) begin
          ep_we = 1'b1;
          cnt_d = (dm_rd_q.count == '1) ? dm_rd_q.count : dm_rd_q.count + 32'd1;
          state_d = S_MUL;
        end else if (node_q == NODE_W'(1)) begin
          state_d = S_DONE;
        end else begin
          node_d = node_q >> 1;
          lvl_d = lvl_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_MUL:  state_d = S_DIVS;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: if (div_rsp.done) state_d = S_WB;
      S_WB: begin
        dm_we = 1'b1;
        if (node_q == NODE_W'(1)) begin
          state_d = S_DONE;
        end else begin
          node_d = node_q >> 1;
          lvl_d = lvl_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_RA: state_d = S_RB;
      S_RB: state_d = S_RC;
      S_RC: state_d = S_RE;
      S_RE: begin
        if (dm_rd_q.cost < kid_cost && !kid_sum[32]) begin
          ivld_d[par_q] = 1'b1;
        end else if (dm_rd_q.cost < kid_cost) begin
          ivld_d[par_q] = 1'b1;
        end else begin
          ivld_d[par_q] = 1'b0;
          dm_we = 1'b1;
          dm_waddr = {1'b0, par_q};
          dm_wdata = '{count: dm_rd_q.count, cost: kid_cost};
        end
        par_d = par_q - 1'b1;
        state_d = (par_q == PAGE_W'(1)) ? S_DONE : S_RA;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{part_start: '0, part_pages: '0, log_total: log_q,
                    model_built: built_q};
          if (op_q == OP_TOUCH) begin
            log_d = log_sum[16] ? '1 : log_sum[15:0];
            out_d.part_start = pstart_sh[PAGE_W-1:0];
            out_d.part_pages = tsize;
            out_d.log_total = log_sum[16] ? '1 : log_sum[15:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      protect_q <= PROTECT_RST;
      log_cost_q <= LOG_COST_RST;
      epoch_q <= 16'd1;
      log_q <= '0;
      round_q <= '0;
      rmod_q <= '0;
      warm_q <= '0;
      ivld_q <= '0;
      clr_all_q <= 1'b1;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      op_q <= '0;
      built_q <= 1'b0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      log_q <= log_d;
      round_q <= round_d;
      rmod_q <= rmod_d;
      warm_q <= warm_d;
      ivld_q <= ivld_d;
      clr_all_q <= clr_all_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      op_q <= op_d;
      built_q <= built_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PROTECT:  protect_q <= cfg_data_i;
          REG_LOG_COST: log_cost_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    node_q <= node_d;
    lvl_q <= lvl_d;
    pick_q <= pick_d;
    plvl_q <= plvl_d;
    par_q <= par_d;
    cnt_q <= cnt_d;
    prod_q <= cnt_q * log_cost_q;
    if (state_q == S_RB) c0_q <= dm_rd_q.cost;
    if (state_q == S_RC) c1_q <= dm_rd_q.cost;
  end

  // epoch marks
  always_ff @(posedge clk_i) begin
    if (ep_we) ep_mem[ep_waddr] <= ep_wdata;
    ep_rd_q <= ep_mem[rd_addr];
  end

  // access counts and costs
  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
    dm_rd_q <= dm_mem[rd_addr];
  end

  `HDPT_ASSERT(a_div_done_in_wait, clk_i, rst_ni, div_rsp.done |-> state_q == S_DIVW,
    "divider finished outside its wait state")
  `HDPT_ASSERT(a_warm_sticks, clk_i, rst_ni, warm_q == WARM_DONE |=> warm_q == WARM_DONE,
    "warmup stage left its final value")
  `HDPT_ASSERT(a_walk_node, clk_i, rst_ni, state_q == S_RD |-> node_q != '0,
    "tree walk read past the root")
  `HDPT_ASSERT_ALWAYS(a_no_node_zero, clk_i, !rst_ni || !ivld_q[0],
    "node zero marked valid")

endmodule

FILE: design/hdpt_div.sv
// bit-serial divider for the node cost, flags quotients of 2^32 and above
// depends on hdpt_pkg
module hdpt_div import hdpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        sat_q;
  logic [31:0] rem_q, quo_q;
  logic [32:0] div_q;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    ge      = rem_sh >= div_q;
    rem_sub = rem_sh - div_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    if (req_i.start) begin
      if ({1'b0, req_i.dividend[63:32]} >= req_i.divisor) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = 6'(DIV_STEPS);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q <= {1'b0, req_i.dividend[63:32]} >= req_i.divisor;
      rem_q <= req_i.dividend[63:32];
      quo_q <= req_i.dividend[31:0];
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign rsp_o = '{done: done_q, sat: sat_q, quot: quo_q};

endmodule

FILE: tb/hierarchical_dirty_page_tracker_tb.sv
// testbench of the dirty page tracker: random and directed operation beats,
// a model of the partition tree that predicts every result beat
// depends on hdpt_pkg and the hierarchical_dirty_page_tracker rtl
module hierarchical_dirty_page_tracker_tb;
  import hdpt_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  hierarchical_dirty_page_tracker u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tree model
  logic [15:0] t_epoch [NODES];
  logic [31:0] t_count [NODES];
  logic [31:0] t_cost  [NODES];
  bit          t_valid [NODES];
  logic [15:0] cur_epoch;
  logic [15:0] log_pages;
  logic [31:0] rounds;
  logic [1:0]  warm;
  logic [15:0] protect_q, log_cost_q;

  in_t  op_queue [$];
  out_t expected_beats [$];
  int   fails = 0;
  int   idle_cycles = 0;
  bit   in_fire = 1'b0;
  bit   hold_req = 1'b0;

  function automatic logic [31:0] node_cost_q8(logic [31:0] cnt, int unsigned size);
    longint unsigned num, den, q, rem, v;
    num = longint'(cnt) * longint'(log_cost_q) * longint'(size);
    den = longint'(rounds) + 1;
    q = num / den;
    rem = num % den;
    if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    v = q * 256 + (rem * 256) / den + longint'(protect_q) * 256;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void leaves_only();
    for (int i = 0; i < NODES; i++) t_valid[i] = (i >= PAGES);
  endfunction

  function automatic void tree_reduce();
    int unsigned lo, hi;
    longint unsigned sum;
    lo = PAGES;
    hi = NODES;
    while (lo > 1) begin
      for (int unsigned i = lo; i + 1 < hi; i += 2) begin
        sum = longint'(t_cost[i]) + longint'(t_cost[i+1]);
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        if (longint'(t_cost[i>>1]) < sum) t_valid[i>>1] = 1'b1;
        else begin
          t_valid[i>>1] = 1'b0;
          t_cost[i>>1] = sum[31:0];
        end
      end
      hi = lo;
      lo = lo >> 1;
    end
  endfunction

  function automatic out_t tracker_step(in_t it);
    out_t r;
    int unsigned node, size, pick, tsize, total;
    r = '0;
    if (it.operation == OP_TOUCH) begin
      node = PAGES + (it.page % PAGES);
      pick = node;
      size = 1;
      tsize = 0;
      while (node > 0) begin
        if (t_valid[node]) begin
          tsize = size;
          pick = node;
        end
        if (t_epoch[node] != cur_epoch) begin
          t_epoch[node] = cur_epoch;
          if (t_count[node] != 32'hFFFF_FFFF) t_count[node]++;
          t_cost[node] = node_cost_q8(t_count[node], size);
        end
        size = size << 1;
        node = node >> 1;
      end
      while (pick < PAGES) pick = pick << 1;
      r.part_start = 8'(pick - PAGES);
      r.part_pages = 9'(tsize);
      total = log_pages + tsize;
      log_pages = (total > 16'hFFFF) ? 16'hFFFF : total[15:0];
    end else if (it.operation == OP_END) begin
      log_pages = '0;
      if (cur_epoch == EPOCH_WRAP) begin
        cur_epoch = '0;
        for (int i = 0; i < NODES; i++) t_epoch[i] = '0;
      end
      cur_epoch = cur_epoch + 16'd1;
    end else if (it.operation == OP_ROUND) begin
      rounds = rounds + 32'd1;
      if (rounds % 100 == 0) begin
        if (warm < WARM_STAGES) begin
          warm++;
          leaves_only();
        end
        if (warm == WARM_STAGES) begin
          warm = WARM_DONE;
          tree_reduce();
          r.model_built = 1'b1;
        end
      end
    end
    r.log_total = log_pages;
    return r;
  endfunction

  // acceptance, prediction and checking
  always @(posedge clk_i) begin
    out_t exp_b;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) expected_beats.push_back(tracker_step(in_data_i));
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_PROTECT) protect_q = cfg_data_i;
      else if (cfg_index_i == REG_LOG_COST) log_cost_q = cfg_data_i;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with none expected, actual %p", $time, out_data_o);
        fails++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_data_o.part_start !== exp_b.part_start ||
            out_data_o.part_pages !== exp_b.part_pages ||
            out_data_o.log_total !== exp_b.log_total ||
            out_data_o.model_built !== exp_b.model_built) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_b, out_data_o);
          fails++;
        end
      end
    end
  end

  // operation driver, bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    logic nv;
    in_t  nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      nv = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (op_queue.size() > 0) begin
        nd = op_queue.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid_i <= nv;
    in_data_i <= nd;
  end

  // receiver stall pattern with one long hold-off
  int mode_left = 0, stall_mode = 0, hold_left = 0;
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 300);
      stall_mode = $urandom_range(0, 2);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_mode == 0) rdy = 1'b1;
    else if (stall_mode == 1) rdy = ($urandom_range(0, 3) != 0);
    else rdy = ($urandom_range(0, 3) == 0);
    out_ready_i <= rdy;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (op_queue.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  function automatic void push_op(op_e o, logic [7:0] pg);
    in_t it;
    it.operation = o;
    it.page = pg;
    op_queue.push_back(it);
  endfunction

  function automatic void push_random(int n, int round_pct);
    in_t it;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      it.page = 8'($urandom_range(0, 255));
      if (k < round_pct) it.operation = OP_ROUND;
      else if (k < round_pct + 12) it.operation = OP_END;
      else if (k < round_pct + 15) it.operation = 2'd3;
      else it.operation = OP_TOUCH;
      op_queue.push_back(it);
    end
  endfunction

  initial begin
    protect_q = PROTECT_RST;
    log_cost_q = LOG_COST_RST;
    for (int i = 0; i < NODES; i++) begin
      t_epoch[i] = '0;
      t_count[i] = '0;
      t_cost[i] = '0;
    end
    leaves_only();
    cur_epoch = 16'd1;
    log_pages = '0;
    rounds = '0;
    warm = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_op(OP_TOUCH, 8'd0);
    push_op(OP_TOUCH, 8'd255);
    push_op(OP_TOUCH, 8'd128);
    push_op(OP_TOUCH, 8'd0);
    push_op(OP_TOUCH, 8'h55);
    push_op(OP_TOUCH, 8'hAA);
    push_op(OP_END, 8'd0);
    push_op(OP_TOUCH, 8'd255);
    op_queue.push_back(in_t'({2'd3, 8'hFF}));
    push_op(OP_ROUND, 8'd7);
    push_op(OP_TOUCH, 8'd1);
    push_op(OP_END, 8'hFF);
    drain();

    reg_write(REG_PROTECT, 16'd0);
    reg_write(REG_LOG_COST, 16'hFFFF);
    push_random(500, 5);
    hold_req = 1'b1;
    drain();

    reg_write(REG_PROTECT, 16'hFFFF);
    reg_write(REG_LOG_COST, 16'd0);
    for (int i = 0; i < 210; i++) begin
      push_op(OP_ROUND, 8'($urandom_range(0, 255)));
      push_random(1, 0);
    end
    drain();

    reg_write(REG_PROTECT, 16'($urandom_range(0, 65535)));
    reg_write(REG_LOG_COST, 16'($urandom_range(0, 65535)));
    push_random(400, 3);
    drain();

    push_random(170, 3);
    drain();

    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
